FILE: design/pjt_pkg.sv
// Package for the process job table: sizes, codes and the structs that
// pass between the table cells and the top level.
// No dependencies.
package pjt_pkg;

  localparam int DEPTH       = 16;
  localparam int PID_W       = 22;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PID_W - 1 - CNT_W;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SET_FG = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CODE_OK        = 2'd0,
    CODE_NOT_FOUND = 2'd1,
    CODE_EMPTY     = 2'd2,
    CODE_FULL      = 2'd3
  } code_t;

  // request broadcast to every cell
  typedef struct packed {
    logic             en;
    func_t            func;
    logic [PID_W-1:0] key;
    logic             fg;
  } cell_cmd_t;

  // passed left to right along the row
  typedef struct packed {
    logic             match;
    logic             fg_found;
    logic [PID_W-1:0] fg_pid;
  } cell_link_t;

  // passed right to left on removal
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic             fg;
  } cell_entry_t;

endpackage

FILE: design/pjt_cell.sv
// One slot of the job table: holds a pid and foreground flag, compares
// the key, and shifts in its right neighbour's entry on removal.
// Depends on pjt_pkg.
module pjt_cell (
  input  logic                 clk,
  input  logic                 occ_i,
  input  logic                 tail_i,
  input  pjt_pkg::cell_cmd_t   cmd_i,
  input  pjt_pkg::cell_link_t  link_i,
  output pjt_pkg::cell_link_t  link_o,
  input  pjt_pkg::cell_entry_t next_i,
  output pjt_pkg::cell_entry_t entry_o
);

  pjt_pkg::cell_entry_t entry_r;
  pjt_pkg::cell_entry_t entry_nxt;
  logic                 hit;
  logic                 sel;
  logic                 fg_here;

  assign hit     = occ_i && (entry_r.pid == cmd_i.key) && !link_i.match;
  assign sel     = link_i.match || hit;
  assign fg_here = occ_i && entry_r.fg;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd_i.en) begin
      case (cmd_i.func)
        pjt_pkg::FUNC_APPEND: begin
          if (tail_i) begin
            entry_nxt.pid = cmd_i.key;
            entry_nxt.fg  = cmd_i.fg;
          end
        end
        pjt_pkg::FUNC_REMOVE: begin
          if (sel) begin
            entry_nxt = next_i;
          end
        end
        pjt_pkg::FUNC_SET_FG: begin
          if (hit) begin
            entry_nxt.fg = cmd_i.fg;
          end
        end
        default: begin
          entry_nxt = entry_r;
        end
      endcase
    end
  end

  always_comb begin
    link_o.match    = sel;
    link_o.fg_found = link_i.fg_found || fg_here;
    if (link_i.fg_found) begin
      link_o.fg_pid = link_i.fg_pid;
    end else if (fg_here) begin
      link_o.fg_pid = entry_r.pid;
    end else begin
      link_o.fg_pid = '0;
    end
  end

  assign entry_o = entry_r;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: design/process_job_table_core.sv
// Top level of the process job table: a row of pjt_cell slots, the job
// count, a result stage and the output register.
// Depends on pjt_pkg and pjt_cell.
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | pid[21:0], fg[22]              | func[1:0]
//  out_    | out | job_count[4:0], fg_found[5],   | code[1:0]
//          |     | fg_pid[27:6]                   |
//
// One request a cycle: the table updates at the accepting edge, the earliest
// foreground search runs along the cell row in the following cycle.
// out_tvalid rises when a result moves into the output register.
// A result waiting in the output register holds one more in the result stage,
// after which in_tready drops. Synchronous active-low reset empties the table.
module process_job_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pjt_pkg::IN_TDATA_W-1:0]  in_tdata,  // pid, fg
  input  logic [1:0]                      in_tuser,  // func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pjt_pkg::OUT_TDATA_W-1:0] out_tdata, // job_count, fg_found, fg_pid
  output logic [1:0]                      out_tuser  // code
);

  localparam int DEPTH = pjt_pkg::DEPTH;
  localparam int CNT_W = pjt_pkg::CNT_W;
  localparam int PID_W = pjt_pkg::PID_W;

  pjt_pkg::cell_cmd_t   cmd;
  pjt_pkg::cell_link_t  link [DEPTH+1];
  pjt_pkg::cell_entry_t ent  [DEPTH];
  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     tail;

  logic                 accept;
  logic                 out_free;
  logic                 move;
  logic                 found;
  logic                 full;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 pend_r, pend_nxt;
  pjt_pkg::code_t       pend_code_r, code_nxt;
  logic [CNT_W-1:0]     pend_count_r;

  logic                 out_valid_r, out_valid_nxt;
  pjt_pkg::code_t       out_code_r;
  logic [CNT_W-1:0]     out_count_r;
  logic                 out_found_r;
  logic [PID_W-1:0]     out_pid_r;

  assign out_free  = !out_valid_r || out_tready;
  assign move      = pend_r && out_free;
  assign in_tready = !pend_r || out_free;
  assign accept    = in_tvalid && in_tready;

  assign cmd.en   = accept;
  assign cmd.func = pjt_pkg::func_t'(in_tuser);
  assign cmd.key  = in_tdata[PID_W-1:0];
  assign cmd.fg   = in_tdata[PID_W];

  assign link[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      pjt_pkg::cell_entry_t next_ent;
      assign occ[gi]  = CNT_W'(gi) < count_r;
      assign tail[gi] = count_r == CNT_W'(gi);
      if (gi == DEPTH - 1) begin : g_last
        assign next_ent = '0;
      end else begin : g_mid
        assign next_ent = ent[gi+1];
      end
      pjt_cell u_cell (
        .clk     (clk),
        .occ_i   (occ[gi]),
        .tail_i  (tail[gi]),
        .cmd_i   (cmd),
        .link_i  (link[gi]),
        .link_o  (link[gi+1]),
        .next_i  (next_ent),
        .entry_o (ent[gi])
      );
    end
  endgenerate

  assign found = link[DEPTH].match;
  assign full  = count_r == CNT_W'(DEPTH);

  always_comb begin
    count_nxt = count_r;
    code_nxt  = pjt_pkg::CODE_NOT_FOUND;
    case (cmd.func)
      pjt_pkg::FUNC_APPEND: begin
        if (full) begin
          code_nxt = pjt_pkg::CODE_FULL;
        end else begin
          code_nxt  = pjt_pkg::CODE_OK;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      pjt_pkg::FUNC_REMOVE: begin
        if (count_r == '0) begin
          code_nxt = pjt_pkg::CODE_EMPTY;
        end else if (found) begin
          code_nxt  = pjt_pkg::CODE_OK;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      pjt_pkg::FUNC_SET_FG: begin
        if (found) begin
          code_nxt = pjt_pkg::CODE_OK;
        end
      end
      default: begin
        code_nxt = pjt_pkg::CODE_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_code_r  <= code_nxt;
      pend_count_r <= count_nxt;
    end
    if (move) begin
      out_code_r  <= pend_code_r;
      out_count_r <= pend_count_r;
      out_found_r <= link[DEPTH].fg_found;
      out_pid_r   <= link[DEPTH].fg_pid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_code_r;
  assign out_tdata  = {{pjt_pkg::OUT_PAD_W{1'b0}}, out_pid_r, out_found_r, out_count_r};

endmodule

FILE: design/pjt_checker.sv
// Port-level checks on the result channel of the job table.
// Depends on pjt_pkg; bound to process_job_table_core below.
module pjt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pjt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);

  localparam int CNT_W = pjt_pkg::CNT_W;
  localparam int PID_W = pjt_pkg::PID_W;

  logic [CNT_W-1:0] cnt;
  logic             fnd;
  logic [PID_W-1:0] fpid;

  assign cnt  = out_tdata[CNT_W-1:0];
  assign fnd  = out_tdata[CNT_W];
  assign fpid = out_tdata[CNT_W+PID_W:CNT_W+1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt <= CNT_W'(pjt_pkg::DEPTH))
    else $error("job count above table depth");

  a_nofg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !fnd |-> fpid == '0)
    else $error("foreground pid without foreground job");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pjt_pkg::CODE_FULL |-> cnt == CNT_W'(pjt_pkg::DEPTH))
    else $error("full reported on a table with room");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pjt_pkg::CODE_EMPTY |-> cnt == '0 && !fnd)
    else $error("empty reported on a table holding jobs");

endmodule

bind process_job_table_core pjt_checker u_pjt_checker (.*);
